>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a reset that disables the check.
`define DFUCR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define DFUCR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dfucr_pkg.sv
// Types, codes and helper functions of the DFU class request handler.
package dfucr_pkg;

   // Transfer size of one download or upload block.
   localparam int XFER_SIZE  = 1024;
   localparam int XFER_SHIFT = $clog2(XFER_SIZE);
   localparam logic [10:0] XFER_LEN = 11'(XFER_SIZE);

   // Request codes.
   localparam logic [2:0] MODE_DNLOAD    = 3'd0;
   localparam logic [2:0] MODE_CLRSTATUS = 3'd1;
   localparam logic [2:0] MODE_ABORT     = 3'd2;
   localparam logic [2:0] MODE_UPLOAD    = 3'd3;
   localparam logic [2:0] MODE_GETSTATUS = 3'd4;
   localparam logic [2:0] MODE_GETSTATE  = 3'd5;
   localparam logic [2:0] MODE_STATUSDONE = 3'd6;

   // DFU state numbers.
   localparam logic [3:0] ST_IDLE          = 4'd2;
   localparam logic [3:0] ST_DNLOAD_SYNC   = 4'd3;
   localparam logic [3:0] ST_DNBUSY        = 4'd4;
   localparam logic [3:0] ST_DNLOAD_IDLE   = 4'd5;
   localparam logic [3:0] ST_MANIFEST_SYNC = 4'd6;
   localparam logic [3:0] ST_MANIFEST      = 4'd7;
   localparam logic [3:0] ST_UPLOAD_IDLE   = 4'd9;
   localparam logic [3:0] ST_ERROR         = 4'd10;

   // Download command bytes of block zero.
   localparam logic [7:0] OP_SETADDR = 8'h21;
   localparam logic [7:0] OP_ERASE   = 8'h41;

   // Register reset values.
   localparam logic [31:0] APP_START_RESET = 32'h0800_4000;
   localparam logic [31:0] FLASH_END_RESET = 32'h0808_0000;

   // Register indexes on the configuration port.
   localparam logic REG_APP_START = 1'b0;
   localparam logic REG_FLASH_END = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] block_number;
      logic [10:0] data_length;
      logic [7:0]  command_byte;
      logic [31:0] command_address;
      logic [23:0] poll_time;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        stall_res;
      logic        status_code;
      logic [3:0]  state_out;
      logic [23:0] poll_timeout_out;
      logic        erase_request;
      logic        program_request;
      logic        upload_request;
      logic [31:0] flash_address;
      logic [10:0] program_length;
      logic        detach;
   } res_type;

   typedef struct packed {
      logic [3:0]  dev_state;
      logic [15:0] saved_block;
      logic [10:0] saved_length;
      logic [7:0]  saved_command;
      logic [31:0] saved_command_address;
      logic [31:0] base_address;
      logic        error_code;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      dev_state:             ST_IDLE,
      saved_block:           16'd0,
      saved_length:          11'd0,
      saved_command:         8'd0,
      saved_command_address: 32'd0,
      base_address:          32'd0,
      error_code:            1'b0
   };

   // Flash address of a block: base plus (block - 2) transfers, wrapped to 32 bits.
   function automatic logic [31:0] block_addr(input logic [31:0] base,
                                              input logic [15:0] blk);
      logic [31:0] offset;
      offset = 32'(blk) - 32'd2;
      return base + (offset << XFER_SHIFT);
   endfunction

endpackage

>>> design/dfu_class_request_fsm.sv
// Top level of the DFU class request handler with its register port.
// Path: an accepted word is held in the input register, then moves to the result register.
// Throughput: one word per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: synchronous, active high; clears the DFU state to idle, the saved
// fields to zero and the address registers to their defaults.
module dfu_class_request_fsm import dfucr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_block_number,
   input  logic [10:0] req_data_length,
   input  logic [7:0]  req_command_byte,
   input  logic [31:0] req_command_address,
   input  logic [23:0] req_poll_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_stall_res,
   output logic        rsp_status_code,
   output logic [3:0]  rsp_state_out,
   output logic [23:0] rsp_poll_timeout_out,
   output logic        rsp_erase_request,
   output logic        rsp_program_request,
   output logic        rsp_upload_request,
   output logic [31:0] rsp_flash_address,
   output logic [10:0] rsp_program_length,
   output logic        rsp_detach,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic        in_valid_ff;
   req_type     in_ff;
   req_type     req_in;
   logic        res_valid_ff;
   res_type     res_ff;
   res_type     res_in;
   ctx_type     ctx_ff;
   ctx_type     ctx_in;
   logic [31:0] app_start_ff;
   logic [31:0] flash_end_ff;
   logic        advance;
   logic        csr_write;

   // Gather the request word from its ports.
   assign req_in = '{
      mode:            req_mode,
      block_number:    req_block_number,
      data_length:     req_data_length,
      command_byte:    req_command_byte,
      command_address: req_command_address,
      poll_time:       req_poll_time
   };

   // The held request moves on when the result register is free or drains.
   assign advance   = in_valid_ff && (!res_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_in;
      end
   end

   // Decision logic between the input and result registers.
   dfucr_step u_step (
      .req       (in_ff),
      .ctx       (ctx_ff),
      .app_start (app_start_ff),
      .flash_end (flash_end_ff),
      .ctx_nxt   (ctx_in),
      .res       (res_in)
   );

   // DFU state is committed when its request moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= CTX_RESET;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         res_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid            = res_valid_ff;
   assign rsp_accepted         = res_ff.accepted;
   assign rsp_stall_res        = res_ff.stall_res;
   assign rsp_status_code      = res_ff.status_code;
   assign rsp_state_out        = res_ff.state_out;
   assign rsp_poll_timeout_out = res_ff.poll_timeout_out;
   assign rsp_erase_request    = res_ff.erase_request;
   assign rsp_program_request  = res_ff.program_request;
   assign rsp_upload_request   = res_ff.upload_request;
   assign rsp_flash_address    = res_ff.flash_address;
   assign rsp_program_length   = res_ff.program_length;
   assign rsp_detach           = res_ff.detach;

   // Address range registers on the register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_start_ff <= APP_START_RESET;
         flash_end_ff <= FLASH_END_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_APP_START) begin
            app_start_ff <= pwdata;
         end else begin
            flash_end_ff <= pwdata;
         end
      end
   end

   assign prdata = (paddr[2] == REG_FLASH_END) ? flash_end_ff : app_start_ff;

endmodule

>>> design/dfucr_step.sv
// Next-state and result logic for one DFU class request.
module dfucr_step import dfucr_pkg::*; (
   input  req_type     req,
   input  ctx_type     ctx,
   input  logic [31:0] app_start,
   input  logic [31:0] flash_end,
   output ctx_type     ctx_nxt,
   output res_type     res
);

   logic [10:0] len;
   logic        in_range;

   // Lengths above one transfer saturate to one transfer.
   assign len = (req.data_length > XFER_LEN) ? XFER_LEN : req.data_length;

   // Set-address target must lie in the application range.
   assign in_range = (req.command_address >= app_start) &&
                     (req.command_address < flash_end);

   // Decode the request against the current state.
   always_comb begin
      ctx_nxt = ctx;
      res = '0;
      res.accepted = 1'b1;
      case (req.mode)
         MODE_DNLOAD: begin
            if (len == 11'd0) begin
               ctx_nxt.dev_state = ST_MANIFEST_SYNC;
            end else begin
               ctx_nxt.saved_block = req.block_number;
               ctx_nxt.saved_length = len;
               ctx_nxt.saved_command = req.command_byte;
               ctx_nxt.saved_command_address = req.command_address;
               ctx_nxt.dev_state = ST_DNLOAD_SYNC;
               if (req.block_number == 16'd0 && req.command_byte == OP_SETADDR) begin
                  if (!in_range) begin
                     ctx_nxt.error_code = 1'b1;
                     ctx_nxt.dev_state = ST_ERROR;
                  end else begin
                     ctx_nxt.base_address = req.command_address;
                  end
               end
            end
         end
         MODE_CLRSTATUS: begin
            if (ctx.dev_state == ST_ERROR) begin
               ctx_nxt.dev_state = ST_IDLE;
            end
         end
         MODE_ABORT: begin
            ctx_nxt.dev_state = ST_IDLE;
         end
         MODE_UPLOAD: begin
            if (ctx.dev_state == ST_IDLE || ctx.dev_state == ST_DNLOAD_IDLE ||
                ctx.dev_state == ST_UPLOAD_IDLE) begin
               ctx_nxt.saved_block = req.block_number;
               ctx_nxt.dev_state = ST_UPLOAD_IDLE;
               if (req.block_number > 16'd1) begin
                  res.upload_request = 1'b1;
                  res.flash_address = block_addr(ctx.base_address, req.block_number);
                  res.program_length = len;
               end
            end else begin
               res.accepted = 1'b0;
               res.stall_res = 1'b1;
            end
         end
         MODE_GETSTATUS: begin
            if (ctx.dev_state == ST_DNLOAD_SYNC) begin
               ctx_nxt.dev_state = ST_DNBUSY;
               res.poll_timeout_out = req.poll_time;
            end else if (ctx.dev_state == ST_MANIFEST_SYNC) begin
               ctx_nxt.dev_state = ST_MANIFEST;
            end else if (ctx.dev_state == ST_ERROR) begin
               res.status_code = ctx.error_code;
            end
         end
         MODE_GETSTATE: begin
         end
         MODE_STATUSDONE: begin
            // Completion of busy issues the saved erase or program.
            if (ctx.dev_state == ST_DNBUSY) begin
               if (ctx.saved_block == 16'd0) begin
                  if (ctx.saved_command == OP_ERASE) begin
                     res.erase_request = 1'b1;
                     res.flash_address = ctx.saved_command_address;
                  end
               end else begin
                  res.program_request = 1'b1;
                  res.flash_address = block_addr(ctx.base_address, ctx.saved_block);
                  res.program_length = ctx.saved_length;
               end
               ctx_nxt.dev_state = ST_DNLOAD_IDLE;
            end else if (ctx.dev_state == ST_MANIFEST) begin
               res.detach = 1'b1;
            end
         end
         default: begin
            res.accepted = 1'b0;
         end
      endcase
      res.state_out = ctx_nxt.dev_state;
   end

endmodule

>>> design/dfucr_checker.sv
// Port-level checks on the DFU class request handler and their binding.
`include "assert_macros.svh"

module dfucr_checker import dfucr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic        rsp_stall_res,
   input logic        rsp_status_code,
   input logic [3:0]  rsp_state_out,
   input logic [23:0] rsp_poll_timeout_out,
   input logic        rsp_erase_request,
   input logic        rsp_program_request,
   input logic        rsp_upload_request,
   input logic [31:0] rsp_flash_address,
   input logic        rsp_detach
);

   // A stalled upload is never reported as accepted.
   `DFUCR_ASSERT(a_stall_refused, clock, reset, rsp_valid && rsp_stall_res |-> !rsp_accepted, "stalled word marked accepted")

   // At most one flash or detach action per result word.
   `DFUCR_ASSERT(a_one_action, clock, reset, rsp_valid |-> $onehot0({rsp_erase_request, rsp_program_request, rsp_upload_request, rsp_detach}), "more than one action in a word")

   // A poll timeout is reported only when entering download busy.
   `DFUCR_ASSERT(a_poll_busy, clock, reset, rsp_valid && rsp_poll_timeout_out != 24'd0 |-> rsp_state_out == ST_DNBUSY, "poll timeout outside busy")

   // A nonzero status is reported only from the error state.
   `DFUCR_ASSERT(a_status_error, clock, reset, rsp_valid && rsp_status_code |-> rsp_state_out == ST_ERROR, "error status outside error state")

   // A result word that is not taken stays on the ports.
   `DFUCR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_state_out) && $stable(rsp_flash_address), "result word changed while stalled")

endmodule

bind dfu_class_request_fsm dfucr_checker u_dfucr_checker (.*);

>>> test/dfu_reply_checker.sv
// Reply checker for the DFU class request handler: predicts each reply and compares it.
`timescale 1ns / 1ps
module dfu_reply_checker import dfucr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_block_number,
   input  logic [10:0] req_data_length,
   input  logic [7:0]  req_command_byte,
   input  logic [31:0] req_command_address,
   input  logic [23:0] req_poll_time,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic        rsp_stall_res,
   input  logic        rsp_status_code,
   input  logic [3:0]  rsp_state_out,
   input  logic [23:0] rsp_poll_timeout_out,
   input  logic        rsp_erase_request,
   input  logic        rsp_program_request,
   input  logic        rsp_upload_request,
   input  logic [31:0] rsp_flash_address,
   input  logic [10:0] rsp_program_length,
   input  logic        rsp_detach,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int unsigned fail_count,
   output int unsigned outstanding,
   output int unsigned replies_checked,
   output int unsigned programs_seen,
   output int unsigned erases_seen,
   output int unsigned uploads_seen,
   output int unsigned detaches_seen,
   output int unsigned stalls_seen
);

   // Replies predicted for accepted request words, oldest first.
   res_type reply_queue[$];

   // Shadow copy of the handler's state and address limits.
   logic [3:0]  dev_state;
   logic [15:0] last_block;
   logic [10:0] last_length;
   logic [7:0]  last_command;
   logic [31:0] last_cmd_addr;
   logic [31:0] base_addr;
   logic        addr_error;
   logic [31:0] app_start;
   logic [31:0] flash_end;

   // Flash address of a numbered block; block two sits at the base address.
   function automatic logic [31:0] flash_block_addr(input logic [15:0] blk);
      return base_addr + ((32'(blk) - 32'd2) * 32'(XFER_SIZE));
   endfunction

   // Works out the reply to one request word and advances the shadow state.
   function automatic res_type next_reply(input req_type w);
      res_type     r;
      logic [10:0] len;
      r = '0;
      r.accepted = 1'b1;
      len = (w.data_length > XFER_LEN) ? XFER_LEN : w.data_length;
      case (w.mode)
         MODE_DNLOAD: begin
            if (len == 11'd0) begin
               dev_state = ST_MANIFEST_SYNC;
            end else begin
               last_block = w.block_number;
               last_length = len;
               last_command = w.command_byte;
               last_cmd_addr = w.command_address;
               dev_state = ST_DNLOAD_SYNC;
               if (w.block_number == 16'd0 && w.command_byte == OP_SETADDR) begin
                  if (w.command_address < app_start || w.command_address >= flash_end) begin
                     addr_error = 1'b1;
                     dev_state = ST_ERROR;
                  end else begin
                     base_addr = w.command_address;
                  end
               end
            end
         end
         MODE_CLRSTATUS: begin
            if (dev_state == ST_ERROR) begin
               dev_state = ST_IDLE;
            end
         end
         MODE_ABORT: begin
            dev_state = ST_IDLE;
         end
         MODE_UPLOAD: begin
            if (dev_state == ST_IDLE || dev_state == ST_DNLOAD_IDLE ||
                dev_state == ST_UPLOAD_IDLE) begin
               last_block = w.block_number;
               dev_state = ST_UPLOAD_IDLE;
               // Blocks zero and one are handled without a flash read.
               if (w.block_number > 16'd1) begin
                  r.upload_request = 1'b1;
                  r.flash_address = flash_block_addr(w.block_number);
                  r.program_length = len;
               end
            end else begin
               r.accepted = 1'b0;
               r.stall_res = 1'b1;
            end
         end
         MODE_GETSTATUS: begin
            if (dev_state == ST_DNLOAD_SYNC) begin
               dev_state = ST_DNBUSY;
               r.poll_timeout_out = w.poll_time;
            end else if (dev_state == ST_MANIFEST_SYNC) begin
               dev_state = ST_MANIFEST;
            end else if (dev_state == ST_ERROR) begin
               r.status_code = addr_error;
            end
         end
         MODE_GETSTATE: begin
         end
         MODE_STATUSDONE: begin
            if (dev_state == ST_DNBUSY) begin
               // Block zero carries a command; only erase produces a request.
               if (last_block == 16'd0) begin
                  if (last_command == OP_ERASE) begin
                     r.erase_request = 1'b1;
                     r.flash_address = last_cmd_addr;
                  end
               end else begin
                  r.program_request = 1'b1;
                  r.flash_address = flash_block_addr(last_block);
                  r.program_length = last_length;
               end
               dev_state = ST_DNLOAD_IDLE;
            end else if (dev_state == ST_MANIFEST) begin
               r.detach = 1'b1;
            end
         end
         default: begin
            r.accepted = 1'b0;
         end
      endcase
      r.state_out = dev_state;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: reply field %s expected 0x%0h, got 0x%0h",
                  $time, field, want, got);
         fail_count++;
      end
   endtask

   // Watch register writes, replies and requests at each rising edge.
   always @(posedge clock) begin : watch
      res_type got;
      res_type want;
      req_type word;
      if (reset) begin
         reply_queue.delete();
         dev_state = ST_IDLE;
         last_block = '0;
         last_length = '0;
         last_command = '0;
         last_cmd_addr = '0;
         base_addr = '0;
         addr_error = 1'b0;
         app_start = APP_START_RESET;
         flash_end = FLASH_END_RESET;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_APP_START) begin
               app_start = pwdata;
            end else begin
               flash_end = pwdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_accepted, rsp_stall_res, rsp_status_code, rsp_state_out,
                   rsp_poll_timeout_out, rsp_erase_request, rsp_program_request,
                   rsp_upload_request, rsp_flash_address, rsp_program_length, rsp_detach};
            if (reply_queue.size() == 0) begin
               $display("%0t ns: reply word with none expected, got 0x%0h", $time, got);
               fail_count++;
            end else begin
               want = reply_queue.pop_front();
               check_field("accepted", want.accepted, got.accepted);
               check_field("stall_res", want.stall_res, got.stall_res);
               check_field("status_code", want.status_code, got.status_code);
               check_field("state_out", want.state_out, got.state_out);
               check_field("poll_timeout_out", want.poll_timeout_out, got.poll_timeout_out);
               check_field("erase_request", want.erase_request, got.erase_request);
               check_field("program_request", want.program_request, got.program_request);
               check_field("upload_request", want.upload_request, got.upload_request);
               check_field("flash_address", want.flash_address, got.flash_address);
               check_field("program_length", want.program_length, got.program_length);
               check_field("detach", want.detach, got.detach);
               replies_checked++;
               programs_seen += got.program_request;
               erases_seen += got.erase_request;
               uploads_seen += got.upload_request;
               detaches_seen += got.detach;
               stalls_seen += got.stall_res;
            end
         end
         if (req_valid && req_ready) begin
            word = {req_mode, req_block_number, req_data_length, req_command_byte,
                    req_command_address, req_poll_time};
            reply_queue.push_back(next_reply(word));
         end
      end
      outstanding = reply_queue.size();
   end

endmodule

>>> test/tb_dfu_class_request_fsm.sv
// Testbench top of the DFU class request handler: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_dfu_class_request_fsm;
   import dfucr_pkg::*;

   localparam logic [2:0] ADDR_APP_START = {REG_APP_START, 2'b00};
   localparam logic [2:0] ADDR_FLASH_END = {REG_FLASH_END, 2'b00};
   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int unsigned PHASE_WORDS = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [15:0] req_block_number = '0;
   logic [10:0] req_data_length = '0;
   logic [7:0]  req_command_byte = '0;
   logic [31:0] req_command_address = '0;
   logic [23:0] req_poll_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accepted;
   logic        rsp_stall_res;
   logic        rsp_status_code;
   logic [3:0]  rsp_state_out;
   logic [23:0] rsp_poll_timeout_out;
   logic        rsp_erase_request;
   logic        rsp_program_request;
   logic        rsp_upload_request;
   logic [31:0] rsp_flash_address;
   logic [10:0] rsp_program_length;
   logic        rsp_detach;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned replies_checked;
   int unsigned programs_seen;
   int unsigned erases_seen;
   int unsigned uploads_seen;
   int unsigned detaches_seen;
   int unsigned stalls_seen;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned words_sent = 0;
   logic [31:0] app_lo = APP_START_RESET;
   logic [31:0] flash_hi = FLASH_END_RESET;

   dfu_class_request_fsm u_dut (.*);

   dfu_reply_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stalls at the rate of the current phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_type request(input logic [2:0] mode, input logic [15:0] blk,
                                       input logic [10:0] len, input logic [7:0] cmd,
                                       input logic [31:0] addr, input logic [23:0] poll);
      return {mode, blk, len, cmd, addr, poll};
   endfunction

   // Present one word after a random gap and hold it until it is taken.
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_mode, req_block_number, req_data_length, req_command_byte,
       req_command_address, req_poll_time} <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      words_sent++;
   endtask

   // Stop sending and wait until every predicted reply has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_limits(input logic [31:0] lo, input logic [31:0] hi);
      drain();
      write_reg(ADDR_APP_START, lo);
      write_reg(ADDR_FLASH_END, hi);
      app_lo = lo;
      flash_hi = hi;
   endtask

   // Set-address target: mostly inside the window, sometimes on or past its edges.
   function automatic logic [31:0] pick_target();
      logic [32:0] span;
      int unsigned choice;
      choice = $urandom_range(9);
      span = 33'(flash_hi) - 33'(app_lo);
      if (flash_hi > app_lo && choice < 6) begin
         return app_lo + 32'(33'($urandom) % span);
      end else if (choice == 6) begin
         return app_lo;
      end else if (choice == 7) begin
         return flash_hi - 32'd1;
      end else if (choice == 8) begin
         return ($urandom_range(1)) ? app_lo - 32'd1 : flash_hi;
      end
      return $urandom;
   endfunction

   function automatic logic [15:0] pick_block();
      return ($urandom_range(3) != 0) ? 16'($urandom_range(1, 40)) : 16'($urandom);
   endfunction

   function automatic logic [10:0] pick_length();
      return ($urandom_range(3) != 0) ? 11'($urandom_range(1, 1024))
                                      : 11'($urandom_range(1, 2047));
   endfunction

   // Mostly complete request sequences with random content, the rest noise.
   task automatic run_random(input int unsigned count);
      int unsigned stop;
      int unsigned pick;
      int unsigned n;
      bit          paused;
      logic [7:0]  cmd;
      stop = words_sent + count;
      paused = 1'b0;
      while (words_sent < stop) begin
         if (!paused && words_sent >= stop - count / 2) begin
            drain();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 25) begin
            // Data block download, status poll and completion.
            send_word(request(MODE_DNLOAD, pick_block(), pick_length(), $urandom,
                              $urandom, $urandom));
            send_word(request(MODE_GETSTATUS, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
            send_word(request(MODE_STATUSDONE, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
         end else if (pick < 40) begin
            // Set-address command, possibly followed by clearing an error.
            send_word(request(MODE_DNLOAD, 16'd0, 11'($urandom_range(5, 1024)), OP_SETADDR,
                              pick_target(), $urandom));
            send_word(request(MODE_GETSTATUS, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
            send_word(request(MODE_STATUSDONE, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
            if ($urandom_range(1)) begin
               send_word(request(MODE_CLRSTATUS, $urandom, $urandom, $urandom, $urandom,
                                 $urandom));
            end
         end else if (pick < 52) begin
            // Erase command, now and then some other block-zero command.
            cmd = ($urandom_range(99) < 85) ? OP_ERASE : 8'($urandom);
            send_word(request(MODE_DNLOAD, 16'd0, pick_length(), cmd, $urandom, $urandom));
            send_word(request(MODE_GETSTATUS, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
            send_word(request(MODE_STATUSDONE, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
         end else if (pick < 64) begin
            // A run of uploads, including the blocks without a flash read.
            n = $urandom_range(1, 4);
            repeat (n) begin
               send_word(request(MODE_UPLOAD, ($urandom_range(3) == 0) ?
                                 16'($urandom_range(1)) : pick_block(),
                                 $urandom, $urandom, $urandom, $urandom));
            end
         end else if (pick < 72) begin
            // End of download through manifestation, then back to idle.
            send_word(request(MODE_DNLOAD, $urandom, 11'd0, $urandom, $urandom, $urandom));
            send_word(request(MODE_GETSTATUS, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
            send_word(request(MODE_STATUSDONE, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
            if ($urandom_range(1)) begin
               send_word(request(MODE_STATUSDONE, $urandom, $urandom, $urandom, $urandom,
                                 $urandom));
            end
            send_word(request(MODE_ABORT, $urandom, $urandom, $urandom, $urandom, $urandom));
         end else if (pick < 78) begin
            n = $urandom_range(2);
            send_word(request((n == 0) ? MODE_GETSTATE : (n == 1) ? MODE_ABORT
                              : MODE_CLRSTATUS, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
         end else begin
            send_word(request(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom,
                              $urandom));
         end
      end
   endtask

   initial begin
      logic [31:0] r0;
      logic [31:0] r1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words under the default address window.
      send_word(request(MODE_GETSTATE, 0, 0, 0, 0, 0));
      send_word(request(MODE_UPLOAD, 16'd0, 11'd64, 0, 0, 0));
      send_word(request(MODE_UPLOAD, 16'd1, 11'd64, 0, 0, 0));
      send_word(request(MODE_UPLOAD, 16'hFFFF, 11'h7FF, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
      send_word(request(MODE_ABORT, 0, 0, 0, 0, 0));
      send_word(request(MODE_DNLOAD, 16'd0, 11'd5, OP_SETADDR, APP_START_RESET, 0));
      send_word(request(MODE_GETSTATUS, 0, 0, 0, 0, 24'hFF_FFFF));
      // Upload while busy must stall.
      send_word(request(MODE_UPLOAD, 16'd2, 11'd16, 0, 0, 0));
      send_word(request(MODE_STATUSDONE, 0, 0, 0, 0, 0));
      send_word(request(MODE_DNLOAD, 16'd0, 11'd5, OP_ERASE, 32'hFFFF_FFFF, 0));
      send_word(request(MODE_GETSTATUS, 0, 0, 0, 0, 0));
      send_word(request(MODE_STATUSDONE, 0, 0, 0, 0, 0));
      // Block one programs one transfer below the base address.
      send_word(request(MODE_DNLOAD, 16'd1, 11'd1024, 0, 0, 0));
      send_word(request(MODE_GETSTATUS, 0, 0, 0, 0, 24'd1));
      send_word(request(MODE_STATUSDONE, 0, 0, 0, 0, 0));
      // Length just over a transfer saturates.
      send_word(request(MODE_DNLOAD, 16'd2, 11'd1025, 0, 0, 0));
      send_word(request(MODE_GETSTATUS, 0, 0, 0, 0, 24'h12_3456));
      send_word(request(MODE_STATUSDONE, 0, 0, 0, 0, 0));
      // Manifestation and a repeated completion.
      send_word(request(MODE_DNLOAD, 16'd3, 11'd0, 0, 0, 0));
      send_word(request(MODE_GETSTATUS, 0, 0, 0, 0, 0));
      send_word(request(MODE_STATUSDONE, 0, 0, 0, 0, 0));
      send_word(request(MODE_STATUSDONE, 0, 0, 0, 0, 0));
      // Address at the exclusive end of flash gives the error state.
      send_word(request(MODE_DNLOAD, 16'd0, 11'd5, OP_SETADDR, FLASH_END_RESET, 0));
      send_word(request(MODE_GETSTATUS, 0, 0, 0, 0, 0));
      send_word(request(MODE_UPLOAD, 16'd4, 11'd32, 0, 0, 0));
      send_word(request(MODE_CLRSTATUS, 0, 0, 0, 0, 0));
      send_word(request(MODE_UNUSED, 16'hFFFF, 11'h7FF, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF));
      send_word(request(MODE_STATUSDONE, 0, 0, 0, 0, 0));

      // Random phases across address windows and idle patterns.
      for (int phase = 0; phase < 8; phase++) begin
         r0 = $urandom;
         r1 = $urandom;
         case (phase)
            1: set_limits(32'h0000_0000, 32'hFFFF_FFFF);
            2: set_limits(32'hFFFF_FFFF, 32'h0000_0000);
            3: set_limits(r0, r0);
            4: set_limits((r0 < r1) ? r0 : r1, (r0 < r1) ? r1 : r0);
            5: set_limits(32'h0000_0000, 32'h0000_0001);
            6: set_limits(32'hFFFF_FFFE, 32'hFFFF_FFFF);
            7: set_limits(APP_START_RESET, FLASH_END_RESET);
            default: begin
            end
         endcase
         send_idle_pct = (phase % 4 == 1) ? 56 : (phase % 4 == 3) ? 17 : 0;
         stall_pct = (phase % 4 == 2) ? 56 : (phase % 4 == 3) ? 17 : 0;
         run_random(PHASE_WORDS);
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d request words over eight address windows and four idle patterns.",
               words_sent);
      $display("Checked %0d replies: %0d programs, %0d erases, %0d uploads, %0d detaches, %0d stalls.",
               replies_checked, programs_seen, erases_seen, uploads_seen, detaches_seen,
               stalls_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
